// ===== rtl/console_line_editor_macros.svh =====
// Assertion macros used by the console line editor RTL (lce_ctrl).
// Each expects clk and rst_n in scope.
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Same-cycle implication
`define LCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console line editor: same-cycle check failed");

// Next-cycle implication
`define LCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console line editor: next-cycle check failed");

`endif

// ===== rtl/lce_pkg.sv =====
package lce_pkg;

    // Default line buffer size, terminator slot included
    localparam int BUFFER_BYTES_DEF = 64;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 7;
    localparam int LENGTH_W = 6;
    localparam int KIND_W   = 2;
    // Address field wide enough for any buffer size up to 256
    localparam int MEM_ADDR_W = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [8:0]         LIMIT_MIN   = 9'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;

    // Line store access from the sequencer
    typedef struct packed {
        logic                  wr_en;
        logic [MEM_ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0]     wr_data;
        logic                  rd_en;
        logic [MEM_ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== rtl/lce_line_mem.sv =====
module lce_line_mem #(
    parameter int BUFFER_BYTES = lce_pkg::BUFFER_BYTES_DEF
) (
    input  logic             clk,
    input  lce_pkg::mem_req_t mem_req,
    output logic [7:0]       rd_data
);
    import lce_pkg::*;

    localparam int DEPTH = BUFFER_BYTES - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
        end
    end

    // registered read port, holds its data until the next read
    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lce_ctrl.sv =====
module lce_ctrl #(
    parameter int BUFFER_BYTES = lce_pkg::BUFFER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [6:0]        cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        out_byte,
    output logic [5:0]        line_length,
    output logic              last,
    output lce_pkg::mem_req_t mem_req,
    input  logic [7:0]        rd_data
);
    import lce_pkg::*;

    `include "console_line_editor_macros.svh"

    localparam int CW = $clog2(BUFFER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_BS1,
        S_BS2,
        S_BS3,
        S_EMPTY,
        S_LINE
    } state_t;

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [BYTE_W-1:0]    char_reg, char_next;
    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic [LENGTH_W-1:0]  out_len_reg, out_len_next;
    logic                 out_last_reg, out_last_next;

    logic [8:0]           lim9;
    logic [8:0]           eff9;
    logic [CW-1:0]        cap;
    logic                 fill_full;
    logic                 out_free;

    // effective line capacity from the limit register
    always_comb
    begin
        lim9 = 9'(limit_reg);
        if (lim9 < LIMIT_MIN)
        begin
            eff9 = LIMIT_MIN;
        end
        else if (lim9 > 9'(BUFFER_BYTES))
        begin
            eff9 = 9'(BUFFER_BYTES);
        end
        else
        begin
            eff9 = lim9;
        end
        cap = CW'(eff9 - 9'd1);
    end

    assign fill_full = (fill_reg >= cap);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        mem_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (rx_byte == CH_CR || rx_byte == CH_LF ||
                        (rx_byte inside {[CH_SPACE:CH_TILDE]} && fill_full))
                    begin
                        // end of line: start emitting what is stored
                        fill_next = '0;
                        if (fill_reg == '0)
                        begin
                            state_next = S_EMPTY;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            idx_next        = '0;
                            len_next        = fill_reg;
                            state_next      = S_LINE;
                        end
                    end
                    else if (rx_byte == CH_BS || rx_byte == CH_DEL)
                    begin
                        if (fill_reg != '0)
                        begin
                            fill_next  = fill_reg - CW'(1);
                            state_next = S_BS1;
                        end
                    end
                    else if (rx_byte inside {[CH_SPACE:CH_TILDE]})
                    begin
                        // store and echo the printable byte
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = MEM_ADDR_W'(fill_reg);
                        mem_req.wr_data = rx_byte;
                        fill_next       = fill_reg + CW'(1);
                        char_next       = rx_byte;
                        state_next      = S_ECHO;
                    end
                end
            end

            S_ECHO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = char_reg;
                    out_len_next   = '0;
                    out_last_next  = !fill_full;
                    if (fill_full)
                    begin
                        // line just filled; the stored bytes follow the echo
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        idx_next        = '0;
                        len_next        = fill_reg;
                        fill_next       = '0;
                        state_next      = S_LINE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_BS1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = CH_BS;
                    out_len_next   = '0;
                    out_last_next  = 1'b0;
                    state_next     = S_BS2;
                end
            end

            S_BS2:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = CH_SPACE;
                    out_len_next   = '0;
                    out_last_next  = 1'b0;
                    state_next     = S_BS3;
                end
            end

            S_BS3:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = CH_BS;
                    out_len_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EMPTY;
                    out_byte_next  = CH_NUL;
                    out_len_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_LINE:
            begin
                // read data holds idx_reg; prefetch the next entry as it leaves
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LINE;
                    out_byte_next  = rd_data;
                    out_len_next   = LENGTH_W'(len_reg);
                    out_last_next  = (idx_reg + CW'(1) == len_reg);
                    if (idx_reg + CW'(1) == len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = MEM_ADDR_W'(idx_reg + CW'(1));
                        idx_next        = idx_reg + CW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        char_reg     <= char_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign out_byte    = out_byte_reg;
    assign line_length = out_len_reg;
    assign last        = out_last_reg;

    // checks
    `LCE_ASSERT_NOW(a_line_fill_cleared, state_reg == S_LINE || state_reg == S_EMPTY, fill_reg == '0)
    `LCE_ASSERT_NOW(a_line_idx_in_range, state_reg == S_LINE, idx_reg < len_reg)
    `LCE_ASSERT_NOW(a_bs_drops_one, state_reg == S_BS1 && $past(state_reg) == S_IDLE, fill_reg == $past(fill_reg) - CW'(1))
    `LCE_ASSERT_NEXT(a_write_then_echo, mem_req.wr_en, state_reg == S_ECHO)

endmodule

// ===== rtl/console_line_editor.sv =====
// Console line editor.
// Input channel: one received byte (rx_byte) per beat, in_valid / in_stall.
// Output channel: kind, out_byte, line_length and last per beat,
// out_valid / out_stall. last marks the final beat caused by an input byte.
// Configuration: cfg_wr_en writes cfg_wr_data into the line limit register;
// write it only while the block is idle (the block does not enforce this).
// Printable bytes are echoed and kept in the line store unless the line is
// already full; backspace on a non-empty line echoes BS, space, BS; CR, LF
// or a full line sends the stored bytes, or one empty-line beat; other bytes
// produce nothing. A byte is taken in S_IDLE; its beats come from the states
// that follow, via the output register: S_ECHO (printable), S_EMPTY (empty
// line), S_BS1 to S_BS3 (backspace), S_LINE per stored byte (line ended by
// CR or LF) or S_ECHO then S_LINE (line filled, echo first). The store's
// single read port sends one stored byte per cycle unless the output stalls.
// A stall on the output holds the registered beat and the sequencer waits;
// in_stall is high until every beat of the current byte is issued.
// Reset clears the fill count, sets the line limit to 64 and empties the
// output register; the line store itself is not cleared.
module console_line_editor #(
    parameter int BUFFER_BYTES = lce_pkg::BUFFER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [5:0] line_length,
    output logic       last
);
    import lce_pkg::*;

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] rd_data;

    // sequencer and output register
    lce_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .line_length (line_length),
        .last        (last),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    // line store
    lce_line_mem #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lce_pkg::*;

    localparam int ITEM_GOAL     = 210;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 12;
    localparam int STORE_DEPTH   = BUFFER_BYTES_DEF - 1;

    // One output beat as seen on the result channel
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   data;
        logic [LENGTH_W-1:0] len;
        logic                last;
    } beat_t;

    typedef enum logic {ROW_RX, ROW_LIMIT} row_op_t;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_mode_t;

    typedef struct packed {
        row_op_t     op;
        logic [7:0]  value;
        exp_mode_t   mode;
        beat_t       typed;
    } row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [6:0] cfg_wr_data = '0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte     = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [5:0] line_length;
    logic       last;

    console_line_editor i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .line_length (line_length),
        .last        (last)
    );

    // Shadow of the editor state
    logic [7:0] line_bytes [STORE_DEPTH];
    int         line_fill  = 0;
    logic [6:0] limit_reg  = LIMIT_RESET;

    beat_t      want_beats [$];
    beat_t      new_beats  [$];

    int         errors      = 0;
    int         rx_sent     = 0;
    int         idle_cycles = 0;
    int         stall_mode  = 0;
    int         stall_run   = 0;
    bit         gaps_on     = 1'b0;
    int         burst_left  = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void add_beat(logic [1:0] k, logic [7:0] d, logic [5:0] n);
        beat_t b;
        b.kind = k;
        b.data = d;
        b.len  = n;
        b.last = 1'b0;
        new_beats.push_back(b);
    endfunction

    // Send the stored line, or a single empty-line beat
    function automatic void flush_line();
        int i;
        if (line_fill == 0)
            add_beat(KIND_EMPTY, CH_NUL, 6'd0);
        else
            for (i = 0; i < line_fill; i++)
                add_beat(KIND_LINE, line_bytes[i], 6'(line_fill));
        line_fill = 0;
    endfunction

    // Beats caused by one received byte; updates the shadow state
    function automatic void edit_step(logic [7:0] c);
        int    lim;
        int    cap;
        beat_t b;
        new_beats.delete();
        lim = int'(limit_reg);
        if (lim < 2)
            lim = 2;
        if (lim > BUFFER_BYTES_DEF)
            lim = BUFFER_BYTES_DEF;
        cap = lim - 1;

        if (c == CH_CR || c == CH_LF)
            flush_line();
        else if (c == CH_BS || c == CH_DEL)
        begin
            if (line_fill > 0)
            begin
                add_beat(KIND_ECHO, CH_BS, 6'd0);
                add_beat(KIND_ECHO, CH_SPACE, 6'd0);
                add_beat(KIND_ECHO, CH_BS, 6'd0);
                line_fill--;
            end
        end
        else if (c >= CH_SPACE && c <= CH_TILDE)
        begin
            // a full line (limit lowered meanwhile) completes without echo
            if (line_fill >= cap)
                flush_line();
            else
            begin
                add_beat(KIND_ECHO, c, 6'd0);
                line_bytes[line_fill] = c;
                line_fill++;
                if (line_fill >= cap)
                    flush_line();
            end
        end

        if (new_beats.size() > 0)
        begin
            b = new_beats.pop_back();
            b.last = 1'b1;
            new_beats.push_back(b);
        end
    endfunction

    function automatic row_t mk_row(row_op_t op, logic [7:0] v, exp_mode_t m,
                                    logic [1:0] k, logic [7:0] d);
        row_t r;
        r.op         = op;
        r.value      = v;
        r.mode       = m;
        r.typed.kind = k;
        r.typed.data = d;
        r.typed.len  = 6'd0;
        r.typed.last = 1'b1;
        return r;
    endfunction

    // Drive one byte in the current burst and log what it should cause
    task automatic send_rx(input logic [7:0] c, input exp_mode_t mode, input beat_t typed);
        int gap;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;

        in_valid = 1'b1;
        rx_byte  = c;
        do
            @(posedge clk);
        while (in_stall);

        edit_step(c);
        if (mode == EXP_MODEL)
            foreach (new_beats[i])
                want_beats.push_back(new_beats[i]);
        else if (mode == EXP_ONE)
            want_beats.push_back(typed);

        if ((c >= CH_SPACE && c <= CH_TILDE) || c == CH_BS || c == CH_DEL ||
            c == CH_CR || c == CH_LF)
            rx_sent++;
        @(negedge clk);
    endtask

    // Limit writes only once the editor has drained
    task automatic set_limit(input logic [6:0] v);
        in_valid   = 1'b0;
        burst_left = 0;
        while (want_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        limit_reg = v;
    endtask

    // A typed line with edits and noise, usually closed by CR or LF
    task automatic send_line();
        int         len;
        int         i;
        int         pick;
        logic [7:0] c;
        beat_t      none;
        none = '0;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while ((c >= CH_SPACE && c <= CH_TILDE) || c == CH_BS || c == CH_DEL ||
                       c == CH_CR || c == CH_LF);
            end
            else if (pick < 3)
                c = $urandom_range(0, 1) ? CH_BS : CH_DEL;
            else
                c = 8'($urandom_range(CH_SPACE, CH_TILDE));
            send_rx(c, EXP_MODEL, none);
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
            send_rx(CH_CR, EXP_MODEL, none);
        else if (pick < 8)
            send_rx(CH_LF, EXP_MODEL, none);
    endtask

    // Receiver stall pattern
    always @(negedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run > 0)
                    stall_run--;
                else
                begin
                    out_stall <= ~out_stall;
                    stall_run = $urandom_range(0, 7);
                end
            end
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin : check_beats
        beat_t got;
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = kind;
            got.data = out_byte;
            got.len  = line_length;
            got.last = last;
            if (want_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: kind %0d byte %0d length %0d last %0d",
                         $time, got.kind, got.data, got.len, got.last);
            end
            else
            begin
                want = want_beats.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.len !== want.len || got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: beat mismatch: expected kind %0d byte %0d length %0d last %0d",
                             $time, want.kind, want.data, want.len, want.last);
                    $display("%0t:                got      kind %0d byte %0d length %0d last %0d",
                             $time, got.kind, got.data, got.len, got.last);
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t       rows [$];
        int         goal;
        int         phase;
        logic [6:0] v;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: empty-line ends, ignored bytes, edits, limit corners
        rows.push_back(mk_row(ROW_RX, CH_CR,    EXP_ONE,   KIND_EMPTY, CH_NUL));
        rows.push_back(mk_row(ROW_RX, CH_LF,    EXP_ONE,   KIND_EMPTY, CH_NUL));
        rows.push_back(mk_row(ROW_RX, CH_BS,    EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, CH_DEL,   EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, 8'h00,    EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, 8'hFF,    EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, 8'h1F,    EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, CH_SPACE, EXP_ONE,   KIND_ECHO,  CH_SPACE));
        rows.push_back(mk_row(ROW_RX, CH_TILDE, EXP_ONE,   KIND_ECHO,  CH_TILDE));
        rows.push_back(mk_row(ROW_RX, CH_BS,    EXP_MODEL, KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, CH_DEL,   EXP_MODEL, KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, "A",      EXP_ONE,   KIND_ECHO,  "A"));
        rows.push_back(mk_row(ROW_RX, CH_LF,    EXP_MODEL, KIND_ECHO,  CH_NUL));
        // limit below the minimum acts as two: every printable byte ends a line
        rows.push_back(mk_row(ROW_LIMIT, 8'd0,  EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, "x",      EXP_MODEL, KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_LIMIT, 8'd1,  EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, "y",      EXP_MODEL, KIND_ECHO,  CH_NUL));
        // limit above the buffer clamps to the buffer size
        rows.push_back(mk_row(ROW_LIMIT, 8'd127, EXP_NONE, KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, "Q",      EXP_ONE,   KIND_ECHO,  "Q"));
        rows.push_back(mk_row(ROW_RX, "R",      EXP_ONE,   KIND_ECHO,  "R"));
        rows.push_back(mk_row(ROW_RX, CH_CR,    EXP_MODEL, KIND_ECHO,  CH_NUL));
        // lowering the limit under a part-filled line
        rows.push_back(mk_row(ROW_LIMIT, 8'd64, EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, "a",      EXP_ONE,   KIND_ECHO,  "a"));
        rows.push_back(mk_row(ROW_RX, "b",      EXP_ONE,   KIND_ECHO,  "b"));
        rows.push_back(mk_row(ROW_RX, "c",      EXP_ONE,   KIND_ECHO,  "c"));
        rows.push_back(mk_row(ROW_LIMIT, 8'd2,  EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, "d",      EXP_MODEL, KIND_ECHO,  CH_NUL));
        // limit reached: echo first, then the line
        rows.push_back(mk_row(ROW_LIMIT, 8'd3,  EXP_NONE,  KIND_ECHO,  CH_NUL));
        rows.push_back(mk_row(ROW_RX, "p",      EXP_ONE,   KIND_ECHO,  "p"));
        rows.push_back(mk_row(ROW_RX, "q",      EXP_MODEL, KIND_ECHO,  CH_NUL));

        gaps_on    = 1'b1;
        stall_mode = 1;
        foreach (rows[i])
        begin
            if (rows[i].op == ROW_LIMIT)
                set_limit(rows[i].value[6:0]);
            else
                send_rx(rows[i].value, rows[i].mode, rows[i].typed);
        end

        // Random phases, each under its own limit and idling pattern
        phase = 0;
        while (rx_sent < ITEM_GOAL)
        begin
            case (phase)
                0: v = 7'd64;
                1: v = 7'd2;
                2: v = 7'd127;
                3: v = 7'd0;
                4: v = 7'd1;
                5: v = 7'd64;
                default: v = 7'($urandom_range(0, 127));
            endcase
            set_limit(v);
            stall_mode = phase % 3;
            gaps_on    = (phase % 4) != 3;
            goal = rx_sent + $urandom_range(20, 40);
            if (goal > ITEM_GOAL)
                goal = ITEM_GOAL;
            while (rx_sent < goal)
                send_line();
            phase++;
        end

        in_valid = 1'b0;
        while (want_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lce_pkg.sv
rtl/lce_line_mem.sv
rtl/lce_ctrl.sv
rtl/console_line_editor.sv
tb/testbench.sv
